>>> hdl/cbif_pkg.sv
// Shared constants and types for the cubic Bezier inflection finder.
package cbif_pkg;

  localparam int ZERO_TOL_W = 32;
  localparam int SNAP_TOL_W = 11;
  localparam int DIST_TOL_W = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_TOL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SNAP_TOL = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DIST_TOL = 2'd2;

  typedef struct packed {
    logic quad;
    logic a_zero;
    logic b_zero;
  } coef_flags_t;

endpackage

>>> hdl/cbif_coef.sv
// Coefficient pipeline: control points to a, b, c, discriminant and zero flags.
module cbif_coef #(
  parameter int CW = 24,
  parameter int F = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [cbif_pkg::ZERO_TOL_W-1:0] zero_tol,
  input  logic signed [CW-1:0]       x0,
  input  logic signed [CW-1:0]       y0,
  input  logic signed [CW-1:0]       x1,
  input  logic signed [CW-1:0]       y1,
  input  logic signed [CW-1:0]       x2,
  input  logic signed [CW-1:0]       y2,
  input  logic signed [CW-1:0]       x3,
  input  logic signed [CW-1:0]       y3,
  input  logic                       quad,
  input  logic [F:0]                 t0,
  input  logic [F:0]                 t1,
  output logic                       out_valid,
  output logic signed [2*CW+8:0]     a,
  output logic signed [2*CW+8:0]     b,
  output logic signed [2*CW+8:0]     c,
  output logic signed [4*CW+20:0]    disc,
  output cbif_pkg::coef_flags_t      flags,
  output logic [F:0]                 t0_out,
  output logic [F:0]                 t1_out
);

  localparam int PW = F + 1;
  localparam int PRW = 2 * CW;
  localparam int SW = 2 * CW + 4;
  localparam int AW = 2 * CW + 9;
  localparam int MW = AW;
  localparam int H = (MW + 1) / 2;
  localparam int HW = MW - H;
  localparam int BBW = 2 * MW;
  localparam int DW = 2 * MW + 3;
  localparam int ZW = (AW > cbif_pkg::ZERO_TOL_W) ? AW : cbif_pkg::ZERO_TOL_W;

  function automatic logic signed [SW-1:0] ext(input logic signed [PRW-1:0] v);
    return {{(SW - PRW){v[PRW-1]}}, v};
  endfunction

  logic [6:0] valid;

  logic signed [CW-1:0] px [4];
  logic signed [CW-1:0] py [4];
  logic                 quad0;
  logic [PW-1:0]        t0_0, t1_0;

  logic signed [PRW-1:0] m01, m02, m03, m10, m12, m13, m20, m21, m23, m30, m31, m32;
  logic                  quad1;
  logic [PW-1:0]         t0_1, t1_1;

  logic signed [SW-1:0] sa2, sb2, sc2;
  logic                 quad2;
  logic [PW-1:0]        t0_2, t1_2;

  logic signed [AW-1:0] a3, b3, c3;
  logic                 quad3;
  logic [PW-1:0]        t0_3, t1_3;

  logic signed [AW-1:0] a4, b4, c4;
  logic                 quad4, za4, zb4, neg4;
  logic [PW-1:0]        t0_4, t1_4;
  logic [2*H-1:0]       bll4, all4;
  logic [H+HW-1:0]      blh4, alh4, ahl4;
  logic [2*HW-1:0]      bhh4, ahh4;

  logic signed [AW-1:0] a5, b5, c5;
  logic                 quad5, za5, zb5, neg5;
  logic [PW-1:0]        t0_5, t1_5;
  logic [BBW-1:0]       bb5, ac5;

  logic signed [SW-1:0] e01, e02, e03, e10, e12, e13, e20, e21, e23, e30, e31, e32;
  logic signed [SW-1:0] sa_next, sb_next, sc_next;
  logic signed [AW-1:0] ae, be, ce;
  logic [MW-1:0]        a_mag, b_mag, c_mag;
  logic [BBW-1:0]       bb_next, ac_next;
  logic [BBW+1:0]       ac4x;
  logic signed [DW-1:0] disc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px[0] <= x0; px[1] <= x1; px[2] <= x2; px[3] <= x3;
      py[0] <= y0; py[1] <= y1; py[2] <= y2; py[3] <= y3;
      quad0 <= quad;
      t0_0 <= t0;
      t1_0 <= t1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m01 <= px[0] * py[1]; m02 <= px[0] * py[2]; m03 <= px[0] * py[3];
      m10 <= px[1] * py[0]; m12 <= px[1] * py[2]; m13 <= px[1] * py[3];
      m20 <= px[2] * py[0]; m21 <= px[2] * py[1]; m23 <= px[2] * py[3];
      m30 <= px[3] * py[0]; m31 <= px[3] * py[1]; m32 <= px[3] * py[2];
      quad1 <= quad0;
      t0_1 <= t0_0;
      t1_1 <= t1_0;
    end
  end

  always_comb begin
    e01 = ext(m01); e02 = ext(m02); e03 = ext(m03);
    e10 = ext(m10); e12 = ext(m12); e13 = ext(m13);
    e20 = ext(m20); e21 = ext(m21); e23 = ext(m23);
    e30 = ext(m30); e31 = ext(m31); e32 = ext(m32);
    sa_next = -e01 + (e02 <<< 1) - e03 + e10 - ((e12 <<< 1) + e12) + (e13 <<< 1)
              - (e20 <<< 1) + e30 + ((e21 <<< 1) + e21) - (e31 <<< 1) - e23 + e32;
    sb_next = (e01 <<< 1) - ((e02 <<< 1) + e02) + e03 - (e10 <<< 1)
              + ((e12 <<< 1) + e12) - e13 + ((e20 <<< 1) + e20)
              - ((e21 <<< 1) + e21) - e30 + e31;
    sc_next = e02 - e01 + e10 - e12 - e20 + e21;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa2 <= sa_next;
      sb2 <= sb_next;
      sc2 <= sc_next;
      quad2 <= quad1;
      t0_2 <= t0_1;
      t1_2 <= t1_1;
    end
  end

  always_comb begin
    ae = AW'(sa2);
    be = AW'(sb2);
    ce = AW'(sc2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a3 <= (ae <<< 4) + (ae <<< 1);
      b3 <= (be <<< 4) + (be <<< 1);
      c3 <= (ce <<< 4) + (ce <<< 1);
      quad3 <= quad2;
      t0_3 <= t0_2;
      t1_3 <= t1_2;
    end
  end

  always_comb begin
    a_mag = a3[AW-1] ? MW'(-a3) : MW'(a3);
    b_mag = b3[AW-1] ? MW'(-b3) : MW'(b3);
    c_mag = c3[AW-1] ? MW'(-c3) : MW'(c3);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a4 <= a3;
      b4 <= b3;
      c4 <= c3;
      quad4 <= quad3;
      t0_4 <= t0_3;
      t1_4 <= t1_3;
      za4 <= (a3 == '0) || (ZW'(a_mag) < ZW'(zero_tol));
      zb4 <= (b3 == '0) || (ZW'(b_mag) < ZW'(zero_tol));
      neg4 <= a3[AW-1] ^ c3[AW-1];
      bll4 <= b_mag[H-1:0] * b_mag[H-1:0];
      blh4 <= b_mag[H-1:0] * b_mag[MW-1:H];
      bhh4 <= b_mag[MW-1:H] * b_mag[MW-1:H];
      all4 <= a_mag[H-1:0] * c_mag[H-1:0];
      alh4 <= a_mag[H-1:0] * c_mag[MW-1:H];
      ahl4 <= a_mag[MW-1:H] * c_mag[H-1:0];
      ahh4 <= a_mag[MW-1:H] * c_mag[MW-1:H];
    end
  end

  always_comb begin
    bb_next = (BBW'(bhh4) << (2 * H)) + (BBW'(blh4) << (H + 1)) + BBW'(bll4);
    ac_next = (BBW'(ahh4) << (2 * H)) + ((BBW'(alh4) + BBW'(ahl4)) << H) + BBW'(all4);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a5 <= a4;
      b5 <= b4;
      c5 <= c4;
      quad5 <= quad4;
      za5 <= za4;
      zb5 <= zb4;
      neg5 <= neg4;
      t0_5 <= t0_4;
      t1_5 <= t1_4;
      bb5 <= bb_next;
      ac5 <= ac_next;
    end
  end

  always_comb begin
    ac4x = {ac5, 2'b00};
    disc_next = neg5 ? (DW'(bb5) + DW'(ac4x)) : (DW'(bb5) - DW'(ac4x));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a <= a5;
      b <= b5;
      c <= c5;
      disc <= disc_next;
      flags.quad <= quad5;
      flags.a_zero <= za5;
      flags.b_zero <= zb5;
      t0_out <= t0_5;
      t1_out <= t1_5;
    end
  end

  assign out_valid = valid[6];

endmodule

>>> hdl/cbif_sqrt.sv
// Pipelined floor square root, one result bit per stage, with sideband.
module cbif_sqrt #(
  parameter int IN_W = 156,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     radicand,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   root,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int RW = IN_W / 2;

  logic [IN_W-1:0]   rem_q  [RW];
  logic [RW-1:0]     root_q [RW];
  logic [SIDE_W-1:0] side_q [RW];
  logic              valid_q [RW];

  for (genvar j = 0; j < RW; j++) begin : g_step
    localparam int K = RW - 1 - j;
    logic [IN_W-1:0]   rem_prev;
    logic [RW-1:0]     root_prev;
    logic [SIDE_W-1:0] side_prev;
    logic              valid_prev;
    logic [IN_W:0]     trial;
    logic              fit;

    if (j == 0) begin : g_first
      assign rem_prev = radicand;
      assign root_prev = '0;
      assign side_prev = side_in;
      assign valid_prev = in_valid;
    end else begin : g_next
      assign rem_prev = rem_q[j-1];
      assign root_prev = root_q[j-1];
      assign side_prev = side_q[j-1];
      assign valid_prev = valid_q[j-1];
    end

    assign trial = ((IN_W + 1)'(root_prev) << (K + 1)) | ((IN_W + 1)'(1) << (2 * K));
    assign fit = {1'b0, rem_prev} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[j] <= 1'b0;
      end else if (en) begin
        valid_q[j] <= valid_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= fit ? IN_W'({1'b0, rem_prev} - trial) : rem_prev;
        root_q[j] <= fit ? (root_prev | (RW'(1) << K)) : root_prev;
        side_q[j] <= side_prev;
      end
    end
  end

  assign out_valid = valid_q[RW-1];
  assign root = root_q[RW-1];
  assign side_out = side_q[RW-1];

endmodule

>>> hdl/cbif_div.sv
// Pipelined rounding divider with saturation, one quotient bit per stage.
module cbif_div #(
  parameter int N_W = 80,
  parameter int D_W = 58,
  parameter int F = 20,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [N_W-1:0] num,
  input  logic signed [D_W-1:0] den,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  out_valid,
  output logic signed [F+3:0]   quot,
  output logic [SIDE_W-1:0]     side_out
);

  localparam int QW = F + 3;
  localparam int RTW = F + 4;
  localparam int RMW = N_W + 2;
  localparam int XW = (RMW > D_W + 1 + QW) ? RMW : (D_W + 1 + QW);

  logic [N_W-1:0]  an;
  logic [D_W-1:0]  ad;
  logic [RMW-1:0]  m_next;
  logic [D_W:0]    d2_next;

  logic [RMW-1:0]    rem0;
  logic [D_W:0]      d20;
  logic              neg0, ovf0, valid0;
  logic [SIDE_W-1:0] side0;

  logic [RMW-1:0]    rem_q  [QW];
  logic [QW-1:0]     q_q    [QW];
  logic [D_W:0]      d2_q   [QW];
  logic              neg_q  [QW];
  logic              ovf_q  [QW];
  logic              valid_q [QW];
  logic [SIDE_W-1:0] side_q [QW];

  logic [QW-1:0] qsat;
  logic          valid_f;

  always_comb begin
    an = num[N_W-1] ? N_W'(-num) : N_W'(num);
    ad = den[D_W-1] ? D_W'(-den) : D_W'(den);
    m_next = {1'b0, an, 1'b0} + RMW'(ad);
    d2_next = {ad, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
    end else if (en) begin
      valid0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem0 <= m_next;
      d20 <= d2_next;
      neg0 <= num[N_W-1] ^ den[D_W-1];
      ovf0 <= XW'(m_next) >= (XW'(d2_next) << QW);
      side0 <= side_in;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int I = QW - 1 - j;
    logic [RMW-1:0]    rem_prev;
    logic [QW-1:0]     q_prev;
    logic [D_W:0]      d2_prev;
    logic              neg_prev, ovf_prev, valid_prev;
    logic [SIDE_W-1:0] side_prev;
    logic [XW-1:0]     trial;
    logic              fit;

    if (j == 0) begin : g_first
      assign rem_prev = rem0;
      assign q_prev = '0;
      assign d2_prev = d20;
      assign neg_prev = neg0;
      assign ovf_prev = ovf0;
      assign valid_prev = valid0;
      assign side_prev = side0;
    end else begin : g_next
      assign rem_prev = rem_q[j-1];
      assign q_prev = q_q[j-1];
      assign d2_prev = d2_q[j-1];
      assign neg_prev = neg_q[j-1];
      assign ovf_prev = ovf_q[j-1];
      assign valid_prev = valid_q[j-1];
      assign side_prev = side_q[j-1];
    end

    assign trial = XW'(d2_prev) << I;
    assign fit = XW'(rem_prev) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[j] <= 1'b0;
      end else if (en) begin
        valid_q[j] <= valid_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= fit ? RMW'(XW'(rem_prev) - trial) : rem_prev;
        q_q[j] <= fit ? (q_prev | (QW'(1) << I)) : q_prev;
        d2_q[j] <= d2_prev;
        neg_q[j] <= neg_prev;
        ovf_q[j] <= ovf_prev;
        side_q[j] <= side_prev;
      end
    end
  end

  always_comb begin
    qsat = q_q[QW-1];
    if (ovf_q[QW-1] || (q_q[QW-1] > (QW'(1) << (F + 2)))) begin
      qsat = QW'(1) << (F + 2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_f <= 1'b0;
    end else if (en) begin
      valid_f <= valid_q[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot <= neg_q[QW-1] ? -RTW'(qsat) : RTW'(qsat);
      side_out <= side_q[QW-1];
    end
  end

  assign out_valid = valid_f;

endmodule

>>> hdl/cubic_bezier_inflection_finder_top.sv
// Top level of the cubic Bezier inflection finder: config, pipeline, root selection.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  p0_x .. p3_y, is_quadratic, interval_start/end
//   out      from block out_valid / out_stall root_count, first_root, second_root
//   cfg      to block   cfg_write            cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; the square root and the dividers
// each produce one bit per stage.
// Reset clears the valid bits and the tolerance registers.
// A stalled output beat freezes the whole pipeline and raises in_stall in the same cycle.
module cubic_bezier_inflection_finder_top #(
  parameter int COORD_WIDTH = 24,
  parameter int PARAM_FRAC_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [cbif_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cbif_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_WIDTH-1:0]     p0_x,
  input  logic signed [COORD_WIDTH-1:0]     p0_y,
  input  logic signed [COORD_WIDTH-1:0]     p1_x,
  input  logic signed [COORD_WIDTH-1:0]     p1_y,
  input  logic signed [COORD_WIDTH-1:0]     p2_x,
  input  logic signed [COORD_WIDTH-1:0]     p2_y,
  input  logic signed [COORD_WIDTH-1:0]     p3_x,
  input  logic signed [COORD_WIDTH-1:0]     p3_y,
  input  logic                              is_quadratic,
  input  logic [PARAM_FRAC_BITS:0]          interval_start,
  input  logic [PARAM_FRAC_BITS:0]          interval_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        root_count,
  output logic [PARAM_FRAC_BITS:0]          first_root,
  output logic [PARAM_FRAC_BITS:0]          second_root
);

  localparam int CW = COORD_WIDTH;
  localparam int F = PARAM_FRAC_BITS;
  localparam int PW = F + 1;
  localparam int AW = 2 * CW + 9;
  localparam int DW = 4 * CW + 21;
  localparam int SQW = DW - 1 + 2 * F;
  localparam int RW = SQW / 2;
  localparam int NW = AW + F + 3;
  localparam int DNW = AW + 1;
  localparam int RTW = F + 4;
  localparam int FLW = $bits(cbif_pkg::coef_flags_t);
  localparam int SQ_SIDE_W = 1 + FLW + 2 * PW + 3 * AW;
  localparam int DV_SIDE_W = 1 + FLW + 2 * PW;

  logic [cbif_pkg::ZERO_TOL_W-1:0] zero_tolerance;
  logic [cbif_pkg::SNAP_TOL_W-1:0] snap_tolerance;
  logic [cbif_pkg::DIST_TOL_W-1:0] distinct_tolerance;

  logic en;

  logic                   cf_valid;
  logic signed [AW-1:0]   cf_a, cf_b, cf_c;
  logic signed [DW-1:0]   cf_disc;
  cbif_pkg::coef_flags_t  cf_flags;
  logic [PW-1:0]          cf_t0, cf_t1;
  logic [SQW-1:0]         sq_in;

  logic                   sq_valid;
  logic [RW-1:0]          sq_root;
  logic [SQ_SIDE_W-1:0]   sq_side;
  logic                   sq_dneg;
  cbif_pkg::coef_flags_t  sq_flags;
  logic [PW-1:0]          sq_t0, sq_t1;
  logic signed [AW-1:0]   sq_a, sq_b, sq_c;

  logic signed [NW-1:0]   bsh, csh, sx;
  logic                   nm_valid;
  logic signed [NW-1:0]   n1, n2;
  logic signed [DNW-1:0]  d1, d2;
  logic [DV_SIDE_W-1:0]   nm_side;

  logic                   dv1_valid, dv2_valid;
  logic signed [RTW-1:0]  q1, q2;
  logic [DV_SIDE_W-1:0]   dv_side;
  logic                   dv2_tag;
  logic                   fn_dneg;
  cbif_pkg::coef_flags_t  fn_flags;
  logic [PW-1:0]          fn_t0, fn_t1;

  logic signed [RTW-1:0]  tz0, tz1, s1, s2, sl;
  logic                   k1, k2, kl;
  logic [RTW:0]           sdiff;
  logic [1:0]             count_next;
  logic [PW-1:0]          first_next, second_next;

  function automatic logic signed [RTW-1:0] snap(input logic signed [RTW-1:0] s,
                                                 input logic signed [RTW-1:0] t,
                                                 input logic [cbif_pkg::SNAP_TOL_W-1:0] tol);
    logic signed [RTW:0] d;
    logic [RTW:0] ad;
    d = (RTW + 1)'(s) - (RTW + 1)'(t);
    ad = d[RTW] ? (RTW + 1)'(-d) : (RTW + 1)'(d);
    return (ad < (RTW + 1)'(tol)) ? t : s;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_tolerance <= '0;
      snap_tolerance <= '0;
      distinct_tolerance <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        cbif_pkg::REG_ZERO_TOL: zero_tolerance <= cfg_data;
        cbif_pkg::REG_SNAP_TOL: snap_tolerance <= cfg_data[cbif_pkg::SNAP_TOL_W-1:0];
        cbif_pkg::REG_DIST_TOL: distinct_tolerance <= cfg_data[cbif_pkg::DIST_TOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  cbif_coef #(.CW(CW), .F(F)) u_coef (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid), .zero_tol(zero_tolerance),
    .x0(p0_x), .y0(p0_y), .x1(p1_x), .y1(p1_y),
    .x2(p2_x), .y2(p2_y), .x3(p3_x), .y3(p3_y),
    .quad(is_quadratic), .t0(interval_start), .t1(interval_end),
    .out_valid(cf_valid), .a(cf_a), .b(cf_b), .c(cf_c), .disc(cf_disc),
    .flags(cf_flags), .t0_out(cf_t0), .t1_out(cf_t1)
  );

  assign sq_in = {cf_disc[DW-2:0], {(2 * F){1'b0}}};

  cbif_sqrt #(.IN_W(SQW), .SIDE_W(SQ_SIDE_W)) u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(cf_valid), .radicand(sq_in),
    .side_in({cf_disc[DW-1], cf_flags, cf_t0, cf_t1, cf_a, cf_b, cf_c}),
    .out_valid(sq_valid), .root(sq_root), .side_out(sq_side)
  );

  assign {sq_dneg, sq_flags, sq_t0, sq_t1, sq_a, sq_b, sq_c} = sq_side;

  always_comb begin
    bsh = {{3{sq_b[AW-1]}}, sq_b, {F{1'b0}}};
    csh = {{3{sq_c[AW-1]}}, sq_c, {F{1'b0}}};
    sx = NW'(sq_root);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_valid <= 1'b0;
    end else if (en) begin
      nm_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1 <= sq_flags.a_zero ? -csh : (-bsh - sx);
      n2 <= -bsh + sx;
      d1 <= sq_flags.a_zero ? {sq_b[AW-1], sq_b} : {sq_a, 1'b0};
      d2 <= {sq_a, 1'b0};
      nm_side <= {sq_dneg, sq_flags, sq_t0, sq_t1};
    end
  end

  cbif_div #(.N_W(NW), .D_W(DNW), .F(F), .SIDE_W(DV_SIDE_W)) u_div_first (
    .clk(clk), .rst(rst), .en(en), .in_valid(nm_valid), .num(n1), .den(d1),
    .side_in(nm_side), .out_valid(dv1_valid), .quot(q1), .side_out(dv_side)
  );

  cbif_div #(.N_W(NW), .D_W(DNW), .F(F), .SIDE_W(1)) u_div_second (
    .clk(clk), .rst(rst), .en(en), .in_valid(nm_valid), .num(n2), .den(d2),
    .side_in(nm_valid), .out_valid(dv2_valid), .quot(q2), .side_out(dv2_tag)
  );

  assign {fn_dneg, fn_flags, fn_t0, fn_t1} = dv_side;

  always_comb begin
    tz0 = RTW'(fn_t0);
    tz1 = RTW'(fn_t1);
    sl = snap(snap(q1, tz0, snap_tolerance), tz1, snap_tolerance);
    s1 = sl;
    s2 = snap(snap(q2, tz1, snap_tolerance), tz0, snap_tolerance);
    kl = (sl > tz0) && (sl < tz1);
    k1 = (s1 > tz0) && (s1 < tz1);
    sdiff = (RTW + 1)'(s1) - (RTW + 1)'(s2);
    if (sdiff[RTW]) begin
      sdiff = -sdiff;
    end
    k2 = (sdiff > (RTW + 1)'(distinct_tolerance)) && (s2 > tz0) && (s2 < tz1);
    count_next = 2'd0;
    first_next = '0;
    second_next = '0;
    if (fn_flags.quad || fn_dneg) begin
      count_next = 2'd0;
    end else if (fn_flags.a_zero) begin
      if (!fn_flags.b_zero && kl) begin
        count_next = 2'd1;
        first_next = sl[PW-1:0];
      end
    end else begin
      count_next = {1'b0, k1} + {1'b0, k2};
      if (k1) begin
        first_next = s1[PW-1:0];
        if (k2) begin
          second_next = s2[PW-1:0];
        end
      end else if (k2) begin
        first_next = s2[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv1_valid && dv2_valid && dv2_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_count <= count_next;
      first_root <= first_next;
      second_root <= second_next;
    end
  end

endmodule
